>>> hw/rtl/sdgr_pkg.sv
// ----------------------------------------------------------------------------
// sdgr_pkg
// shared types and constants for the synced clock divider with gate/ramp out
// ----------------------------------------------------------------------------
package sdgr_pkg;

	// sample timer and period width
	localparam int TIMER_WIDTH = 32;
	localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

	// magnitude of measured_interval * divisions + jitter offset
	localparam int PABS_W = 34;
	localparam int WIDE_W = (TIMER_WIDTH > PABS_W) ? TIMER_WIDTH : PABS_W;

	// ramp quotient bits (Q1.16) and the iteration counter for them
	localparam int RAMP_BITS = 17;
	localparam int DCNT_W    = $clog2(RAMP_BITS);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_DIV   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_JITTER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_CYCLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_JITTER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE = 3'd5;

	// register reset values
	localparam logic [23:0] BASE_PERIOD_RST = 24'd48000;
	localparam logic [8:0]  CLOCK_DIV_RST   = 9'd1;
	localparam logic [15:0] DUTY_CYCLE_RST  = 16'd32768;

	// output mode codes
	localparam logic MODE_GATE = 1'b0;
	localparam logic MODE_RAMP = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDGE,
		ST_MUL,
		ST_OFF,
		ST_SUM,
		ST_TICK,
		ST_DIV_INIT,
		ST_DIV,
		ST_OUT
	} sdgr_state_t;

	typedef struct packed {
		logic load_in;
		logic do_edge;
		logic do_mul;
		logic do_off;
		logic do_sum;
		logic do_tick;
		logic div_init;
		logic div_step;
		logic load_out;
	} sdgr_cmd_t;

	typedef struct packed {
		logic div_last;
	} sdgr_sts_t;

endpackage

>>> hw/rtl/sdgr_ctrl.sv
// ----------------------------------------------------------------------------
// sdgr_ctrl
// sequencer: walks one item through edge detect, period math and ramp divide
// ----------------------------------------------------------------------------
module sdgr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output sdgr_pkg::sdgr_cmd_t cmd,
	input  sdgr_pkg::sdgr_sts_t sts
);

	sdgr_pkg::sdgr_state_t state_q, state_d;
	logic                  m_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sdgr_pkg::ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			sdgr_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = sdgr_pkg::ST_EDGE;
				end
			end
			sdgr_pkg::ST_EDGE: begin
				cmd.do_edge = 1'b1;
				state_d     = sdgr_pkg::ST_MUL;
			end
			sdgr_pkg::ST_MUL: begin
				cmd.do_mul = 1'b1;
				state_d    = sdgr_pkg::ST_OFF;
			end
			sdgr_pkg::ST_OFF: begin
				cmd.do_off = 1'b1;
				state_d    = sdgr_pkg::ST_SUM;
			end
			sdgr_pkg::ST_SUM: begin
				cmd.do_sum = 1'b1;
				state_d    = sdgr_pkg::ST_TICK;
			end
			sdgr_pkg::ST_TICK: begin
				cmd.do_tick = 1'b1;
				state_d     = sdgr_pkg::ST_DIV_INIT;
			end
			sdgr_pkg::ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = sdgr_pkg::ST_DIV;
			end
			sdgr_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = sdgr_pkg::ST_OUT;
			end
			sdgr_pkg::ST_OUT: begin
				// wait for the output register to drain
				if (!m_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = sdgr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sdgr_pkg::ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = m_valid_q;

endmodule

>>> hw/rtl/sdgr_dp.sv
// ----------------------------------------------------------------------------
// sdgr_dp
// datapath: config registers, sync edge state, period math, ramp divider
// ----------------------------------------------------------------------------
module sdgr_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sdgr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sdgr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_sync_present,
	input  logic [15:0]                         in_sync_sample,
	input  logic [15:0]                         in_rate_random,
	input  logic [15:0]                         in_duty_random,
	input  sdgr_pkg::sdgr_cmd_t                 cmd,
	output sdgr_pkg::sdgr_sts_t                 sts,
	output logic [15:0]                         out_value,
	output logic                                tick_started
);

	localparam int TW = sdgr_pkg::TIMER_WIDTH;
	localparam int RB = sdgr_pkg::RAMP_BITS;

	// configuration (the base period only loads meas_q, so it is not kept)
	logic [8:0]  div_q;
	logic [23:0] rjit_q;
	logic [15:0] duty_cfg_q;
	logic [15:0] djit_q;
	logic        mode_q;

	// input item
	logic        sync_on_q;
	logic [15:0] sync_val_q;
	logic [15:0] rate_rnd_q;
	logic [15:0] duty_rnd_q;

	// block state
	logic [TW-1:0] timer_q;
	logic [TW-1:0] period_q;
	logic [16:0]   duty_thr_q;
	logic [23:0]   meas_q;
	logic [23:0]   icnt_q;
	logic [15:0]   prev_q;
	logic          armed_q;
	logic [8:0]    ecnt_q;
	logic          tick_q;

	// period math
	logic [32:0] base_prod_q;
	logic [40:0] rprod_q;
	logic [32:0] dprod_q;
	logic [25:0] roff_q;
	logic [17:0] doff_q;
	logic [34:0] psum_q;
	logic [18:0] dsum_q;

	// ramp divider
	logic [TW-1:0]                  rem_q;
	logic [RB-1:0]                  quo_q;
	logic                           sat_q;
	logic [sdgr_pkg::DCNT_W-1:0]    dcnt_q;

	// result
	logic [15:0] out_value_q;
	logic        out_tick_q;

	// edge detect
	logic [23:0] icnt_inc;
	logic [16:0] diff;
	logic        diff_neg, diff_pos, arm_n, rise;
	logic [8:0]  eff_div, ecnt_inc;
	logic        div_reached;

	assign icnt_inc    = (icnt_q == '1) ? icnt_q : icnt_q + 24'd1;
	assign diff        = {sync_val_q[15], sync_val_q} - {prev_q[15], prev_q};
	assign diff_neg    = diff[16];
	assign diff_pos    = !diff[16] && (diff != '0);
	assign arm_n       = armed_q | diff_neg;
	assign rise        = sync_on_q && arm_n && diff_pos;
	assign eff_div     = (div_q == '0) ? 9'd1 : div_q;
	assign ecnt_inc    = ecnt_q + 9'd1;
	assign div_reached = (ecnt_inc >= eff_div);

	// products
	logic signed [40:0] rprod_n;
	logic signed [32:0] dprod_n;
	logic        [32:0] base_prod_n;

	assign rprod_n     = $signed({1'b0, rjit_q}) * $signed(rate_rnd_q);
	assign dprod_n     = $signed({1'b0, djit_q}) * $signed(duty_rnd_q);
	assign base_prod_n = 33'(meas_q) * 33'(eff_div);

	// truncation toward zero of a divide by 32768
	logic [40:0] rbias;
	logic [32:0] dbias;

	assign rbias = rprod_q + {26'd0, {15{rprod_q[40]}}};
	assign dbias = dprod_q + {18'd0, {15{dprod_q[32]}}};

	// magnitude, clip, zero guard
	logic [34:0]                   pneg;
	logic [sdgr_pkg::PABS_W-1:0]   pabs;
	logic [sdgr_pkg::WIDE_W-1:0]   pwide;
	logic [TW-1:0]                 pclip, period_n;
	logic [18:0]                   dneg;
	logic [16:0]                   dabs;
	logic [TW-1:0]                 timer_inc;

	assign pneg     = -psum_q;
	assign pabs     = psum_q[34] ? pneg[33:0] : psum_q[33:0];
	assign pwide    = sdgr_pkg::WIDE_W'(pabs);
	assign pclip    = (pwide > sdgr_pkg::WIDE_W'(sdgr_pkg::TIMER_MAX)) ?
		sdgr_pkg::TIMER_MAX : pwide[TW-1:0];
	assign period_n = (pclip == '0) ? TW'(1) : pclip;
	assign dneg     = -dsum_q;
	assign dabs     = dsum_q[18] ? dneg[16:0] : dsum_q[16:0];
	assign timer_inc = (timer_q == sdgr_pkg::TIMER_MAX) ? timer_q : timer_q + TW'(1);

	// one restoring divide step per cycle
	logic [TW:0] trial, trial_sub;
	logic        trial_ge;
	logic [RB-1:0] ramp;

	assign trial     = (dcnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign trial_ge  = trial >= {1'b0, period_q};
	assign trial_sub = trial - {1'b0, period_q};
	assign ramp      = sat_q ? '1 : quo_q;
	assign sts.div_last = (dcnt_q == sdgr_pkg::DCNT_W'(RB - 1));

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q      <= sdgr_pkg::CLOCK_DIV_RST;
			rjit_q     <= '0;
			duty_cfg_q <= sdgr_pkg::DUTY_CYCLE_RST;
			djit_q     <= '0;
			mode_q     <= sdgr_pkg::MODE_GATE;
			timer_q    <= '0;
			period_q   <= '0;
			duty_thr_q <= '0;
			meas_q     <= sdgr_pkg::BASE_PERIOD_RST;
			icnt_q     <= '0;
			prev_q     <= '0;
			armed_q    <= 1'b0;
			ecnt_q     <= '0;
			tick_q     <= 1'b0;
			dcnt_q     <= '0;
		end else begin
			if (cmd.do_edge) begin
				icnt_q <= rise ? '0 : icnt_inc;
				if (sync_on_q) begin
					armed_q <= rise ? 1'b0 : arm_n;
					prev_q  <= sync_val_q;
					if (rise) begin
						meas_q <= icnt_inc;
						ecnt_q <= div_reached ? '0 : ecnt_inc;
					end
					tick_q <= rise && div_reached;
				end else begin
					tick_q <= (timer_q >= period_q);
				end
			end
			if (cmd.do_tick) begin
				if (tick_q) begin
					period_q   <= period_n;
					duty_thr_q <= dabs;
					timer_q    <= TW'(1);
				end else begin
					timer_q <= timer_inc;
				end
			end
			if (cmd.div_init)
				dcnt_q <= '0;
			else if (cmd.div_step)
				dcnt_q <= dcnt_q + sdgr_pkg::DCNT_W'(1);
			if (cfg_we) begin
				unique case (cfg_index)
					sdgr_pkg::REG_BASE_PERIOD: meas_q     <= cfg_data;
					sdgr_pkg::REG_CLOCK_DIV:   div_q      <= cfg_data[8:0];
					sdgr_pkg::REG_RATE_JITTER: rjit_q     <= cfg_data;
					sdgr_pkg::REG_DUTY_CYCLE:  duty_cfg_q <= cfg_data[15:0];
					sdgr_pkg::REG_DUTY_JITTER: djit_q     <= cfg_data[15:0];
					sdgr_pkg::REG_OUTPUT_MODE: mode_q     <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sync_on_q  <= in_sync_present;
			sync_val_q <= in_sync_sample;
			rate_rnd_q <= in_rate_random;
			duty_rnd_q <= in_duty_random;
		end
		if (cmd.do_mul) begin
			base_prod_q <= base_prod_n;
			rprod_q     <= rprod_n;
			dprod_q     <= dprod_n;
		end
		if (cmd.do_off) begin
			roff_q <= rbias[40:15];
			doff_q <= dbias[32:15];
		end
		if (cmd.do_sum) begin
			psum_q <= {2'b00, base_prod_q} + {{9{roff_q[25]}}, roff_q};
			dsum_q <= {3'b000, duty_cfg_q} + {doff_q[17], doff_q};
		end
		if (cmd.div_init) begin
			sat_q <= (period_q == '0) || ({1'b0, timer_q} >= {period_q, 1'b0});
			rem_q <= timer_q;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_sub[TW-1:0] : trial[TW-1:0];
			quo_q <= {quo_q[RB-2:0], trial_ge};
		end
		if (cmd.load_out) begin
			if (mode_q == sdgr_pkg::MODE_RAMP)
				out_value_q <= ramp[RB-1] ? 16'hFFFF : ramp[15:0];
			else
				out_value_q <= (ramp < duty_thr_q) ? 16'hFFFF : 16'h0000;
			out_tick_q <= tick_q;
		end
	end

	assign out_value    = out_value_q;
	assign tick_started = out_tick_q;

endmodule

>>> hw/rtl/synced_clock_divider_gate_ramp.sv
// ----------------------------------------------------------------------------
// synced_clock_divider_gate_ramp
// clock divider with external sync, jitter and gate or ramp output
// ----------------------------------------------------------------------------
// One input item is one audio sample. Without sync the block restarts its
// period whenever the sample timer reaches it; with sync connected, every
// clock_divisions-th rising edge of the sync signal restarts it at the
// measured edge interval times clock_divisions. Each new period and duty
// threshold gets a random offset scaled by the jitter registers (magnitude
// taken, a zero period becomes one). The result is the ramp timer/period in
// Q0.16 (saturated) or a gate that is high while the ramp is below the duty
// threshold. From acceptance to a loaded result an item goes through edge
// detection, the period arithmetic (multiply, offset, sum, tick), divider
// setup, the restoring divider that forms the ramp quotient one bit per
// cycle, and the output register load. The block takes no new item before
// the result is loaded; the next item is taken in the idle state after
// that, while the result waits in the output register. A result still
// unread when the next one is ready holds the block until it drains.
// Configuration writes are meant for when the block is idle.
// ----------------------------------------------------------------------------
module synced_clock_divider_gate_ramp (
	input  logic                            clk,
	input  logic                            arst_n,

	// configuration write port
	input  logic                            cfg_we,
	input  logic [sdgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sdgr_pkg::CFG_DATA_W-1:0] cfg_data,

	// input items
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [47:0]                     s_tdata,  // sync_sample, rate_random, duty_random
	input  logic                            s_tuser,  // sync_present

	// result items
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata,  // out_value
	output logic                            m_tuser   // tick_started
);

	sdgr_pkg::sdgr_cmd_t cmd;
	sdgr_pkg::sdgr_sts_t sts;

	// sequencer owns both handshakes and the output valid
	sdgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath holds config, timer/period state and the output register
	sdgr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_sync_present (s_tuser),
		.in_sync_sample  (s_tdata[15:0]),
		.in_rate_random  (s_tdata[31:16]),
		.in_duty_random  (s_tdata[47:32]),
		.cmd             (cmd),
		.sts             (sts),
		.out_value       (m_tdata),
		.tick_started    (m_tuser)
	);

endmodule

>>> tb/synced_clock_divider_gate_ramp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// synced_clock_divider_gate_ramp_tb
// self-checking bench for the synced clock divider with gate/ramp output
// ----------------------------------------------------------------------------
// A tracker object follows the divider sample by sample: it keeps its own
// copy of the registers, the timer, the period and the sync edge state, and
// queues the output it expects for every accepted sample. Each output item
// is checked against the oldest queued one. A short directed run covers
// the start-up and corner settings, then random settings and random sample
// streams (runs of sync waves mixed with free-running stretches) follow
// under several idle and stall patterns.
// ----------------------------------------------------------------------------

typedef struct {
	bit               sync_on;
	bit signed [15:0] sync_val;
	bit signed [15:0] rate_rnd;
	bit signed [15:0] duty_rnd;
} sample_item_t;

typedef struct {
	bit [15:0] value;
	bit        tick;
} gate_ramp_out_t;

localparam longint unsigned TIMER_LIMIT = 64'(sdgr_pkg::TIMER_MAX);
localparam longint unsigned COUNT_LIMIT = (64'd1 << 24) - 1;
localparam longint unsigned RAMP_FULL   = (64'd1 << sdgr_pkg::RAMP_BITS) - 1;
localparam longint unsigned Q16_ONE     = 64'd65536;
localparam longint unsigned OUT_MAX     = 64'd65535;
localparam longint          Q15_ONE     = 32768;
localparam bit [15:0]       GATE_HIGH   = 16'hFFFF;
localparam bit [15:0]       GATE_LOW    = 16'h0000;
localparam int              PRINT_CAP   = 100;

class ramp_gate_tracker;
	bit [23:0] base_period;
	bit [8:0]  clock_div;
	bit [23:0] rate_jitter;
	bit [15:0] duty_cycle;
	bit [15:0] duty_jitter;
	bit        output_mode;

	longint unsigned  sample_timer;
	longint unsigned  period_len;
	longint unsigned  measured_interval;
	longint unsigned  interval_count;
	bit [16:0]        duty_threshold;
	bit signed [15:0] last_sync;
	bit               armed;
	bit [8:0]         edge_count;

	gate_ramp_out_t pending_outputs[$];
	int mismatches;
	int compared;
	int period_starts;

	function new();
		base_period       = sdgr_pkg::BASE_PERIOD_RST;
		clock_div         = sdgr_pkg::CLOCK_DIV_RST;
		rate_jitter       = '0;
		duty_cycle        = sdgr_pkg::DUTY_CYCLE_RST;
		duty_jitter       = '0;
		output_mode       = sdgr_pkg::MODE_GATE;
		sample_timer      = 0;
		period_len        = 0;
		duty_threshold    = '0;
		measured_interval = sdgr_pkg::BASE_PERIOD_RST;
		interval_count    = 0;
		last_sync         = '0;
		armed             = 1'b0;
		edge_count        = '0;
		mismatches        = 0;
		compared          = 0;
		period_starts     = 0;
	endfunction

	function int pending();
		return pending_outputs.size();
	endfunction

	function void write_reg(logic [sdgr_pkg::CFG_IDX_W-1:0] idx,
			logic [sdgr_pkg::CFG_DATA_W-1:0] data);
		case (idx)
		sdgr_pkg::REG_BASE_PERIOD: begin
			base_period       = data;
			measured_interval = data;
		end
		sdgr_pkg::REG_CLOCK_DIV:   clock_div   = data[8:0];
		sdgr_pkg::REG_RATE_JITTER: rate_jitter = data;
		sdgr_pkg::REG_DUTY_CYCLE:  duty_cycle  = data[15:0];
		sdgr_pkg::REG_DUTY_JITTER: duty_jitter = data[15:0];
		sdgr_pkg::REG_OUTPUT_MODE: output_mode = data[0];
		default: ;
		endcase
	endfunction

	function longint unsigned divisions();
		return (clock_div == 0) ? 64'd1 : 64'(clock_div);
	endfunction

	// new period and duty threshold, both with jitter and magnitude taken
	function void start_period(bit signed [15:0] rate_rnd, bit signed [15:0] duty_rnd);
		longint offset;
		longint span;
		longint duty_sum;
		longint unsigned mag;
		offset = longint'(rate_jitter) * longint'(rate_rnd) / Q15_ONE;
		span   = longint'(measured_interval * divisions()) + offset;
		mag    = (span < 0) ? -span : span;
		if (mag > TIMER_LIMIT)
			mag = TIMER_LIMIT;
		if (mag == 0)
			mag = 1;
		period_len   = mag;
		sample_timer = 0;
		duty_sum = longint'(duty_cycle) + longint'(duty_jitter) * longint'(duty_rnd) / Q15_ONE;
		duty_threshold = 17'((duty_sum < 0) ? -duty_sum : duty_sum);
		period_starts++;
	endfunction

	function longint unsigned ramp_q16();
		longint unsigned q;
		longint unsigned r;
		if (period_len == 0)
			return RAMP_FULL;
		q = sample_timer / period_len;
		r = sample_timer % period_len;
		if (q >= 2)
			return RAMP_FULL;
		return q * Q16_ONE + (r * Q16_ONE) / period_len;
	endfunction

	function void take_sample(sample_item_t it);
		gate_ramp_out_t res;
		int diff;
		longint unsigned ramp;
		res.tick = 1'b0;
		if (interval_count < COUNT_LIMIT)
			interval_count++;
		if (it.sync_on) begin
			diff = int'(it.sync_val) - int'(last_sync);
			if (diff < 0)
				armed = 1'b1;
			if (armed && diff > 0) begin
				armed             = 1'b0;
				measured_interval = interval_count;
				interval_count    = 0;
				edge_count        = edge_count + 9'd1;
				if (64'(edge_count) >= divisions()) begin
					start_period(it.rate_rnd, it.duty_rnd);
					res.tick   = 1'b1;
					edge_count = '0;
				end
			end
			last_sync = it.sync_val;
		end else if (sample_timer >= period_len) begin
			start_period(it.rate_rnd, it.duty_rnd);
			res.tick = 1'b1;
		end
		if (sample_timer < TIMER_LIMIT)
			sample_timer++;
		ramp = ramp_q16();
		if (output_mode == sdgr_pkg::MODE_RAMP)
			res.value = (ramp > OUT_MAX) ? GATE_HIGH : 16'(ramp);
		else
			res.value = (ramp < 64'(duty_threshold)) ? GATE_HIGH : GATE_LOW;
		pending_outputs.push_back(res);
	endfunction

	task report(string what);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	task check_output(logic [15:0] value, logic tick);
		gate_ramp_out_t want;
		if (pending_outputs.size() == 0) begin
			report($sformatf("unexpected output value %0h tick %0b", value, tick));
			return;
		end
		want = pending_outputs.pop_front();
		compared++;
		if (value !== want.value)
			report($sformatf("out_value %0h, expected %0h", value, want.value));
		if (tick !== want.tick)
			report($sformatf("tick_started %0b, expected %0b", tick, want.tick));
	endtask

	task check_leftovers();
		if (pending_outputs.size() != 0)
			report($sformatf("%0d expected outputs never arrived", pending_outputs.size()));
	endtask
endclass

module synced_clock_divider_gate_ramp_tb;

	import sdgr_pkg::*;

	localparam int RESET_CYCLES = 5;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 50;

	// indexes outside the register map, written to see them ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [47:0]           s_tdata   = '0; // sync_sample, rate_random, duty_random
	logic                  s_tuser   = 1'b0; // sync_present
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [15:0]           m_tdata;  // out_value
	logic                  m_tuser;  // tick_started

	ramp_gate_tracker tracker;

	// idle percentages of the current phase
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// long receiver hold-off, requested by the main flow
	int hold_seq  = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// random stream shape: runs of sync or free samples, square-ish sync wave
	int run_left   = 0;
	bit run_synced = 1'b0;
	int wave_left  = 0;
	bit wave_high  = 1'b0;

	int cycles       = 0;
	int samples_sent = 0;
	int settings_used = 1;

	synced_clock_divider_gate_ramp uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// output side: check every accepted item, then choose the next ready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_output(m_tdata, m_tuser);
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			// long hold-off so the block fills up and stalls its input
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// watchdog; last statement of its process
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d outputs still due", cycles,
				tracker.pending());
			$display("Verification failed");
			$finish;
		end
	end

	function automatic sample_item_t sample_of(bit on, bit [15:0] sv, bit [15:0] rr,
			bit [15:0] dr);
		sample_item_t it;
		it.sync_on  = on;
		it.sync_val = sv;
		it.rate_rnd = rr;
		it.duty_rnd = dr;
		return it;
	endfunction

	// mostly well-formed sync waves with random levels, some free runs and noise
	function automatic sample_item_t random_sample();
		sample_item_t it;
		it.rate_rnd = 16'($urandom);
		it.duty_rnd = 16'($urandom);
		it.sync_val = 16'($urandom);
		if (run_left == 0) begin
			run_synced = ($urandom_range(0, 2) != 0);
			run_left   = $urandom_range(4, 40);
		end
		run_left--;
		it.sync_on = run_synced;
		if (run_synced && $urandom_range(0, 9) != 0) begin
			if (wave_left == 0) begin
				wave_high = !wave_high;
				wave_left = $urandom_range(1, 12);
			end
			wave_left--;
			it.sync_val = wave_high ? 16'($urandom_range(1, 32767))
				: -16'($urandom_range(1, 32768));
		end
		return it;
	endfunction

	task set_idling(idle_mode_t mode);
		case (mode)
		IDLE_NONE: begin
			send_idle_pct  = 0;
			recv_stall_pct = 0;
		end
		IDLE_SENDER: begin
			send_idle_pct  = 86;
			recv_stall_pct = 0;
		end
		IDLE_RECEIVER: begin
			send_idle_pct  = 0;
			recv_stall_pct = 86;
		end
		default: begin
			send_idle_pct  = 20;
			recv_stall_pct = 20;
		end
		endcase
	endtask

	// offer one sample, with random gaps before it, and wait for acceptance
	task send_sample(sample_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.sync_on;
		s_tdata  <= {it.duty_rnd, it.rate_rnd, it.sync_val};
		do
			@(posedge clk);
		while (!s_tready);
		tracker.take_sample(it);
		samples_sent++;
	endtask

	// stop offering and wait until every expected output is back
	task close_phase();
		s_tvalid <= 1'b0;
		while (tracker.pending() > 0)
			@(posedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		tracker.write_reg(idx, data);
	endtask

	task configure(logic [23:0] base, logic [8:0] div, logic [23:0] rjit,
			logic [15:0] duty, logic [15:0] djit, logic mode);
		write_reg(REG_BASE_PERIOD, base);
		write_reg(REG_CLOCK_DIV, 24'(div));
		write_reg(REG_RATE_JITTER, rjit);
		write_reg(REG_DUTY_CYCLE, 24'(duty));
		write_reg(REG_DUTY_JITTER, 24'(djit));
		write_reg(REG_OUTPUT_MODE, 24'(mode));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// small periods and divisions mostly, so that ticks come often
	task random_settings();
		logic [23:0] base;
		logic [8:0]  div;
		logic [23:0] rjit;
		logic [15:0] duty;
		logic [15:0] djit;
		logic        mode;
		base = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(1, 40));
		case ($urandom_range(0, 9))
		0, 1: div = 9'($urandom);
		2: div = 9'($urandom_range(7, 16));
		default: div = 9'($urandom_range(0, 6));
		endcase
		case ($urandom_range(0, 9))
		0: rjit = 24'($urandom);
		1, 2, 3, 4: rjit = 24'($urandom_range(0, 30));
		default: rjit = '0;
		endcase
		duty = 16'($urandom);
		djit = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'h0000;
		mode = ($urandom_range(0, 1) != 0) ? MODE_RAMP : MODE_GATE;
		configure(base, div, rjit, duty, djit, mode);
	endtask

	initial begin
		tracker = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(IDLE_NONE);

		// reset settings: sync connected but no edge yet, so no period exists
		send_sample(sample_of(1'b1, 16'h0000, 16'($urandom), 16'($urandom)));
		send_sample(sample_of(1'b1, 16'h7FFF, 16'($urandom), 16'($urandom)));
		// fall arms, a flat sample keeps it armed, the rise starts a period
		send_sample(sample_of(1'b1, 16'h8000, 16'($urandom), 16'($urandom)));
		send_sample(sample_of(1'b1, 16'h8000, 16'($urandom), 16'($urandom)));
		send_sample(sample_of(1'b1, 16'h0000, 16'h8000, 16'h7FFF));
		// free running on the measured interval
		send_sample(sample_of(1'b0, 16'hFFFF, 16'h7FFF, 16'h8000));
		send_sample(sample_of(1'b0, 16'h0000, 16'h8000, 16'h7FFF));
		send_sample(sample_of(1'b0, 16'($urandom), 16'hFFFF, 16'h0000));
		send_sample(sample_of(1'b0, 16'($urandom), 16'h0000, 16'hFFFF));
		close_phase();

		// zero base and zero divisions: period forced to one, duty jitter extremes
		write_reg(REG_SPARE_6, 24'($urandom));
		write_reg(REG_SPARE_7, 24'($urandom));
		configure(24'd0, 9'd0, 24'd0, 16'hFFFF, 16'hFFFF, MODE_RAMP);
		send_sample(sample_of(1'b0, 16'($urandom), 16'h8000, 16'h8000));
		send_sample(sample_of(1'b0, 16'($urandom), 16'h7FFF, 16'h7FFF));
		send_sample(sample_of(1'b0, 16'($urandom), 16'h8000, 16'h8000));
		send_sample(sample_of(1'b0, 16'($urandom), 16'h7FFF, 16'h0000));
		send_sample(sample_of(1'b0, 16'($urandom), 16'h0001, 16'hFFFF));
		send_sample(sample_of(1'b0, 16'($urandom), 16'hFFFF, 16'h7FFF));
		close_phase();

		// largest base and divisions: period saturates at the timer limit
		configure(24'hFFFFFF, 9'h1FF, 24'hFFFFFF, 16'h0000, 16'h0000, MODE_GATE);
		send_sample(sample_of(1'b0, 16'($urandom), 16'h8000, 16'h8000));
		send_sample(sample_of(1'b0, 16'($urandom), 16'h7FFF, 16'h7FFF));
		send_sample(sample_of(1'b0, 16'($urandom), 16'($urandom), 16'($urandom)));
		close_phase();

		// large negative jitter on a short interval: magnitude of the period
		configure(24'd1, 9'd1, 24'hFFFFFF, 16'h8000, 16'h4000, MODE_RAMP);
		send_sample(sample_of(1'b1, 16'h8000, 16'($urandom), 16'($urandom)));
		send_sample(sample_of(1'b1, 16'h7FFF, 16'h8000, 16'h8000));
		send_sample(sample_of(1'b0, 16'($urandom), 16'($urandom), 16'($urandom)));
		send_sample(sample_of(1'b0, 16'($urandom), 16'($urandom), 16'($urandom)));
		close_phase();

		// random settings and streams under rotating idle patterns
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_settings();
			set_idling(idle_mode_t'(p % 4));
			if (p == 4)
				hold_seq++;
			repeat (PHASE_ITEMS) send_sample(random_sample());
			close_phase();
		end

		// let any stray output show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		tracker.check_leftovers();

		$display("covered %0d samples under %0d register settings, %0d period starts",
			samples_sent, settings_used, tracker.period_starts);
		$display("%0d outputs compared, %0d mismatches", tracker.compared,
			tracker.mismatches);
		if (tracker.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
